// ----- src/kdhp_pkg.sv -----
// shared constants, payload types, operation codes and controller states
`default_nettype none

package kdhp_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int DIMENSIONS    = 3;
    localparam int MAX_CELLS     = 256;
    localparam int COORD_W       = 32;
    localparam int RANGE_W       = 11;

    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_SET_RANGE  = 3'd1,
        OP_PARTITION  = 3'd2,
        OP_READ_COORD = 3'd3,
        OP_READ_RANGE = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]                operation;
        logic [9:0]                particle_index;
        logic [1:0]                axis;
        logic signed [COORD_W-1:0] coordinate_in;
        logic [7:0]                cell_id;
        logic [7:0]                left_child;
        logic [7:0]                right_child;
        logic signed [COORD_W-1:0] cut_value;
        logic [RANGE_W-1:0]        range_start_in;
        logic [RANGE_W-1:0]        range_stop_in;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] coordinate_out;
        logic [RANGE_W-1:0]        range_start_out;
        logic [RANGE_W-1:0]        range_stop_out;
        logic [RANGE_W-1:0]        split_point;
        logic                      status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COORD_RD,
        S_RANGE_RD,
        S_PART_RANGE,
        S_SCAN_I,
        S_SCAN_J,
        S_SWAP_I,
        S_SWAP_J,
        S_FETCH,
        S_WR_LEFT,
        S_WR_RIGHT,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- src/kdhp_if.sv -----
// valid/ready channel carrying one payload per transaction
`default_nettype none

interface kdhp_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/kd_cell_hoare_partition.sv -----
// k-d cell partitioner: coordinate row memory, cell range memory and scan controller
// Takes one transaction at a time and answers each with one result. In a partition
// the two scan pointers each read one row per cycle from the two-port row memory, a
// swap writes the two rows one after the other through its single write port, and
// the child ranges go through the single port of the range memory one after the other.
// A new transaction is taken while the previous result still waits at the output.
// Memories are not cleared: a read of a never written row or cell returns garbage.
`default_nettype none

module kd_cell_hoare_partition #(
    parameter int P_MAX_PARTICLES = kdhp_pkg::MAX_PARTICLES,
    parameter int P_DIMENSIONS    = kdhp_pkg::DIMENSIONS,
    parameter int P_MAX_CELLS     = kdhp_pkg::MAX_CELLS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kdhp_if.sink      i_req,
    kdhp_if.source    o_rsp
);
    import kdhp_pkg::*;

    localparam int AW = $clog2(P_MAX_PARTICLES);
    localparam int IW = $clog2(P_MAX_PARTICLES + 1);
    localparam int CW = $clog2(P_MAX_CELLS);

    typedef logic [P_DIMENSIONS-1:0][COORD_W-1:0] t_row;

    t_row                       r_coord_mem [P_MAX_PARTICLES];
    logic [2*RANGE_W-1:0]       r_range_mem [P_MAX_CELLS];

    t_state                     r_state, n_state;
    t_req                       r_req, n_req;
    t_rsp                       r_res, n_res;
    t_rsp                       r_out;
    logic                       r_out_valid;
    logic [IW-1:0]              r_b, n_b, r_e, n_e, r_i, n_i, r_j, n_j;
    t_row                       r_row_a, r_row_b;
    logic [2*RANGE_W-1:0]       r_range_rd;

    t_req                       req;
    logic                       accept, slot_free, req_err;
    logic                       pidx_ok, axis_ok, cell_ok, lc_ok, rc_ok, rng_ok;
    logic signed [COORD_W-1:0]  coord_a, coord_b;
    logic [RANGE_W-1:0]         rb, re;
    logic                       part_bad, part_empty, i_go, j_go;
    logic [AW-1:0]              rd_a, rd_b, c_wa;
    logic                       c_we;
    t_row                       c_wd;
    logic [P_DIMENSIONS-1:0]    c_wm;
    logic                       g_we;
    logic [CW-1:0]              g_wa, g_ra;
    logic [2*RANGE_W-1:0]       g_wd;

    assign req         = i_req.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign pidx_ok = 32'(req.particle_index) < P_MAX_PARTICLES;
    assign axis_ok = 32'(req.axis) < P_DIMENSIONS;
    assign cell_ok = 32'(req.cell_id) < P_MAX_CELLS;
    assign lc_ok   = 32'(req.left_child) < P_MAX_CELLS;
    assign rc_ok   = 32'(req.right_child) < P_MAX_CELLS;
    assign rng_ok  = (req.range_start_in <= req.range_stop_in)
                     && (32'(req.range_stop_in) <= P_MAX_PARTICLES);

    always_comb begin
        unique case (req.operation)
            OP_LOAD, OP_READ_COORD: req_err = !(pidx_ok && axis_ok);
            OP_SET_RANGE:           req_err = !(cell_ok && rng_ok);
            OP_READ_RANGE:          req_err = !cell_ok;
            OP_PARTITION:           req_err = !(cell_ok && lc_ok && rc_ok && axis_ok);
            default:                req_err = 1'b1;
        endcase
    end

    always_comb begin
        coord_a = '0;
        coord_b = '0;
        for (int d = 0; d < P_DIMENSIONS; d++) begin
            if (32'(r_req.axis) == d) begin
                coord_a = r_row_a[d];
                coord_b = r_row_b[d];
            end
        end
    end

    assign rb         = r_range_rd[2*RANGE_W-1:RANGE_W];
    assign re         = r_range_rd[RANGE_W-1:0];
    assign part_bad   = (rb > re) || (32'(re) > P_MAX_PARTICLES);
    assign part_empty = (rb == re);
    assign i_go       = (r_i < r_e) && (coord_a < r_req.cut_value);
    assign j_go       = (r_j > r_b) && (r_req.cut_value < coord_b);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (req_err) begin
                        n_state = S_RESP;
                    end else begin
                        unique case (req.operation)
                            OP_READ_COORD: n_state = S_COORD_RD;
                            OP_READ_RANGE: n_state = S_RANGE_RD;
                            OP_PARTITION:  n_state = S_PART_RANGE;
                            default:       n_state = S_RESP;
                        endcase
                    end
                end
            end
            S_COORD_RD: n_state = S_RESP;
            S_RANGE_RD: n_state = S_RESP;
            S_PART_RANGE: begin
                priority if (part_bad) begin
                    n_state = S_RESP;
                end else if (part_empty) begin
                    n_state = S_WR_LEFT;
                end else begin
                    n_state = S_SCAN_I;
                end
            end
            S_SCAN_I: n_state = i_go ? S_SCAN_I : S_SCAN_J;
            S_SCAN_J: begin
                priority if (j_go) begin
                    n_state = S_SCAN_J;
                end else if (r_i >= r_j) begin
                    n_state = S_WR_LEFT;
                end else begin
                    n_state = S_SWAP_I;
                end
            end
            S_SWAP_I:   n_state = S_SWAP_J;
            S_SWAP_J:   n_state = S_FETCH;
            S_FETCH:    n_state = S_SCAN_I;
            S_WR_LEFT:  n_state = S_WR_RIGHT;
            S_WR_RIGHT: n_state = S_RESP;
            S_RESP:     n_state = slot_free ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req = r_req;
        n_res = r_res;
        n_b   = r_b;
        n_e   = r_e;
        n_i   = r_i;
        n_j   = r_j;
        c_we  = 1'b0;
        c_wa  = r_i[AW-1:0];
        c_wd  = r_row_b;
        c_wm  = '1;
        g_we  = 1'b0;
        g_wa  = CW'(req.cell_id);
        g_wd  = {req.range_start_in, req.range_stop_in};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req        = req;
                    n_res        = '0;
                    n_res.status = req_err;
                    if (!req_err && req.operation == OP_LOAD) begin
                        c_we = 1'b1;
                        c_wa = AW'(req.particle_index);
                        for (int d = 0; d < P_DIMENSIONS; d++) begin
                            c_wd[d] = req.coordinate_in;
                            c_wm[d] = (32'(req.axis) == d);
                        end
                    end
                    if (!req_err && req.operation == OP_SET_RANGE) begin
                        g_we = 1'b1;
                    end
                end
            end
            S_COORD_RD: n_res.coordinate_out = coord_a;
            S_RANGE_RD: begin
                n_res.range_start_out = rb;
                n_res.range_stop_out  = re;
            end
            S_PART_RANGE: begin
                if (part_bad) begin
                    n_res.status = 1'b1;
                end else begin
                    n_b = IW'(rb);
                    n_e = IW'(re);
                    n_i = IW'(rb);
                    n_j = IW'(re) - IW'(1);
                end
            end
            S_SCAN_I: begin
                if (i_go) begin
                    n_i = r_i + IW'(1);
                end
            end
            S_SCAN_J: begin
                if (j_go) begin
                    n_j = r_j - IW'(1);
                end
            end
            S_SWAP_I: c_we = 1'b1;
            S_SWAP_J: begin
                c_we = 1'b1;
                c_wa = r_j[AW-1:0];
                c_wd = r_row_a;
            end
            S_FETCH: begin
                n_i = r_i + IW'(1);
                n_j = r_j - IW'(1);
            end
            S_WR_LEFT: begin
                n_res.split_point = RANGE_W'(r_i);
                g_we = 1'b1;
                g_wa = CW'(r_req.left_child);
                g_wd = {RANGE_W'(r_b), RANGE_W'(r_i)};
            end
            S_WR_RIGHT: begin
                g_we = 1'b1;
                g_wa = CW'(r_req.right_child);
                g_wd = {RANGE_W'(r_i), RANGE_W'(r_e)};
            end
            S_RESP: ;
            default: ;
        endcase
    end

    assign rd_a = (r_state == S_IDLE) ? AW'(req.particle_index) : n_i[AW-1:0];
    assign rd_b = n_j[AW-1:0];
    assign g_ra = CW'(req.cell_id);

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            for (int d = 0; d < P_DIMENSIONS; d++) begin
                if (c_wm[d]) begin
                    r_coord_mem[c_wa][d] <= c_wd[d];
                end
            end
        end
        r_row_a <= r_coord_mem[rd_a];
        r_row_b <= r_coord_mem[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_range_mem[g_wa] <= g_wd;
        end
        r_range_rd <= r_range_mem[g_ra];
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_b   <= n_b;
        r_e   <= n_e;
        r_i   <= n_i;
        r_j   <= n_j;
        if (r_state == S_RESP && slot_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RESP && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/kdhp_checker.sv -----
// port-level checks of the partitioner and their binding to the top level
`default_nettype none

module kdhp_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire kdhp_pkg::t_rsp i_rsp
);
    import kdhp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rsp))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rsp.status |->
            i_rsp.coordinate_out == '0 && i_rsp.range_start_out == '0
            && i_rsp.range_stop_out == '0 && i_rsp.split_point == '0)
        else $error("error result carries data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction taken while busy");

    a_split_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rsp.split_point != '0 |->
            i_rsp.coordinate_out == '0 && i_rsp.range_start_out == '0
            && i_rsp.range_stop_out == '0)
        else $error("partition result mixes fields");

endmodule

bind kd_cell_hoare_partition kdhp_checker u_kdhp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);

`default_nettype wire
